// ===== design/teq_pkg.sv =====
package teq_pkg;

	localparam int MAX_RESULTS = 32;
	localparam int POP_CW = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		REQ_SCHEDULE = 2'd0,
		REQ_PROCESS  = 2'd1,
		REQ_CLEAR    = 2'd2,
		REQ_UNUSED   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUE      = 3'd2,
		ST_NONE_DUE = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_POP
	} fsm_t;

	typedef struct packed {
		logic [31:0] ev_time;
		logic [1:0]  kind;
		logic [7:0]  handler;
		logic [63:0] payload;
	} entry_t;

endpackage

// ===== design/timed_event_queue_top.sv =====
// Channel | Direction | Handshake             | Word
// request | in        | in_valid / in_ready   | req_type, req_time, payload_kind,
//         |           |                       | handler_id, payload_value
// result  | out       | out_valid / out_ready | status, fired_time, current_time,
//         |           |                       | fired_kind, fired_handler,
//         |           |                       | fired_payload, last_result
//
// Schedule and clear go back to back when the result is taken at once.
// Process enters the pop state, where the head cell pops one event per cycle
// through the cell chain while the result register is free.
// arst_n clears the fill count, the controller and out_valid; cell contents stay.
// A stalled result register holds the controller; requests wait until it frees.
module timed_event_queue_top #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] req_time,
	input  logic [1:0]  payload_kind,
	input  logic [7:0]  handler_id,
	input  logic [63:0] payload_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] fired_time,
	output logic [31:0] current_time,
	output logic [1:0]  fired_kind,
	output logic [7:0]  fired_handler,
	output logic [63:0] fired_payload,
	output logic        last_result
);
	import teq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// queue state: sorted chain, head at cell 0
	entry_t               cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_le;
	logic [QUEUE_DEPTH-1:0] cell_occ;
	logic [CW-1:0]        count_q, count_d;
	cell_op_t             op;
	entry_t               new_entry;

	// controller
	fsm_t                 state_q, state_d;
	logic [31:0]          now_q, now_d;
	logic [POP_CW-1:0]    npop_q, npop_d;

	// result register
	logic                 out_valid_q;
	logic                 load;
	status_t              status_q, status_d;
	entry_t               res_q, res_d;
	logic [31:0]          cur_q, cur_d;
	logic                 last_q, last_d;

	logic                 out_free;
	logic                 head_due;
	logic                 last_pop;

	assign new_entry = '{ev_time: req_time, kind: payload_kind,
		handler: handler_id, payload: payload_value};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign cell_occ[i] = count_q > CW'(i);
		teq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.cmp_time   (req_time),
			.occ        (cell_occ[i]),
			.prev_le    ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
			.new_entry  (new_entry),
			.prev_entry (cell_entry[(i == 0) ? 0 : i - 1]),
			.next_entry (cell_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
			.entry      (cell_entry[i]),
			.le         (cell_le[i])
		);
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == FSM_IDLE) && out_free;

	assign head_due = (count_q != '0) && (cell_entry[0].ev_time <= now_q);
	// this pop ends the request if the pop budget runs out, the queue empties or the next head is not due
	assign last_pop = (npop_q == POP_CW'(MAX_RESULTS - 1)) || (count_q == CW'(1))
		|| (cell_entry[1].ev_time > now_q);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		now_d    = now_q;
		npop_d   = npop_q;
		op       = CELL_HOLD;
		load     = 1'b0;
		status_d = ST_ACCEPTED;
		res_d    = '0;
		cur_d    = '0;
		last_d   = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				if (in_valid && in_ready) begin
					case (req_type)
						REQ_SCHEDULE: begin
							load = 1'b1;
							if (count_q < CW'(QUEUE_DEPTH)) begin
								op       = CELL_INSERT;
								count_d  = count_q + CW'(1);
								status_d = ST_ACCEPTED;
							end else begin
								status_d = ST_FULL;
							end
						end
						REQ_PROCESS: begin
							now_d   = req_time;
							npop_d  = '0;
							state_d = FSM_POP;
						end
						REQ_CLEAR: begin
							load     = 1'b1;
							count_d  = '0;
							status_d = ST_CLEARED;
						end
						default: ;
					endcase
				end
			end
			FSM_POP: begin
				if (out_free) begin
					load  = 1'b1;
					cur_d = now_q;
					if (head_due) begin
						status_d = ST_DUE;
						res_d    = cell_entry[0];
						last_d   = last_pop;
						op       = CELL_POP;
						count_d  = count_q - CW'(1);
						npop_d   = npop_q + POP_CW'(1);
						if (last_pop) begin
							state_d = FSM_IDLE;
						end
					end else begin
						// only reached before the first pop
						status_d = ST_NONE_DUE;
						state_d  = FSM_IDLE;
					end
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		now_q  <= now_d;
		npop_q <= npop_d;
		if (load) begin
			status_q <= status_d;
			res_q    <= res_d;
			cur_q    <= cur_d;
			last_q   <= last_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign fired_time    = res_q.ev_time;
	assign current_time  = cur_q;
	assign fired_kind    = res_q.kind;
	assign fired_handler = res_q.handler;
	assign fired_payload = res_q.payload;
	assign last_result   = last_q;

endmodule

// ===== design/teq_cell.sv =====
module teq_cell (
	input  logic              clk,
	input  teq_pkg::cell_op_t op,
	input  logic [31:0]       cmp_time,
	input  logic              occ,
	input  logic              prev_le,
	input  teq_pkg::entry_t   new_entry,
	input  teq_pkg::entry_t   prev_entry,
	input  teq_pkg::entry_t   next_entry,
	output teq_pkg::entry_t   entry,
	output logic              le
);
	import teq_pkg::*;

	entry_t entry_q;

	// stays in place on insert when its time is at or before the new one
	assign le = occ && (entry_q.ev_time <= cmp_time);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (!le) begin
					entry_q <= prev_le ? new_entry : prev_entry;
				end
			end
			CELL_POP: begin
				entry_q <= next_entry;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/teq_checker.sv =====
module teq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [31:0] fired_time,
	input logic [31:0] current_time,
	input logic        last_result
);
	import teq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fired_time)
			&& $stable(last_result))
		else $error("result word changed while stalled");

	a_due_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DUE) |-> fired_time <= current_time)
		else $error("fired event not yet due");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ACCEPTED || status == ST_FULL || status == ST_CLEARED
			|| status == ST_NONE_DUE) |-> last_result)
		else $error("single-result request without last mark");

	// a stalled result word blocks the request side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

endmodule

bind timed_event_queue_top teq_checker u_teq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.fired_time   (fired_time),
	.current_time (current_time),
	.last_result  (last_result)
);

// ===== sim/timed_event_queue_checker.sv =====
module timed_event_queue_checker #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] req_time,
	input  logic [1:0]  payload_kind,
	input  logic [7:0]  handler_id,
	input  logic [63:0] payload_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [31:0] fired_time,
	input  logic [31:0] current_time,
	input  logic [1:0]  fired_kind,
	input  logic [7:0]  fired_handler,
	input  logic [63:0] fired_payload,
	input  logic        last_result,
	output int          mismatch_count,
	output int          pending_words,
	output int          results_checked,
	output int          events_fired,
	output int          events_dropped
);
	import teq_pkg::*;

	// field order matches the port concatenation in the sampling block
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] ftime;
		logic [31:0] now;
		logic [1:0]  kind;
		logic [7:0]  handler;
		logic [63:0] payload;
		logic        last;
	} result_t;

	entry_t      sorted_events [QUEUE_DEPTH];
	int unsigned queued;
	result_t     awaited_results [$];
	int          mismatches;
	int          checked;
	int          fired;
	int          dropped;

	function automatic void predict_request(logic [1:0] rtype, logic [31:0] rtime,
			logic [1:0] kind, logic [7:0] hnd, logic [63:0] pay);
		result_t     w;
		int unsigned pos;
		int unsigned i;
		int          popped;
		w = '0;
		w.last = 1'b1;
		popped = 0;
		case (rtype)
		REQ_SCHEDULE: begin
			if (queued >= QUEUE_DEPTH) begin
				w.status = ST_FULL;
			end else begin
				// insert behind every event with time <= new time
				pos = 0;
				while (pos < queued && sorted_events[pos].ev_time <= rtime)
					pos++;
				for (i = queued; i > pos; i--)
					sorted_events[i] = sorted_events[i - 1];
				sorted_events[pos] = '{ev_time: rtime, kind: kind, handler: hnd,
					payload: pay};
				queued++;
				w.status = ST_ACCEPTED;
			end
			awaited_results.push_back(w);
		end
		REQ_PROCESS: begin
			while (popped < MAX_RESULTS && queued > 0 && sorted_events[0].ev_time <= rtime)
			begin
				w = '0;
				w.status  = ST_DUE;
				w.ftime   = sorted_events[0].ev_time;
				w.now     = rtime;
				w.kind    = sorted_events[0].kind;
				w.handler = sorted_events[0].handler;
				w.payload = sorted_events[0].payload;
				awaited_results.push_back(w);
				for (i = 1; i < queued; i++)
					sorted_events[i - 1] = sorted_events[i];
				queued--;
				popped++;
			end
			if (popped == 0) begin
				w = '0;
				w.status = ST_NONE_DUE;
				w.now    = rtime;
				w.last   = 1'b1;
				awaited_results.push_back(w);
			end else begin
				awaited_results[awaited_results.size() - 1].last = 1'b1;
			end
		end
		REQ_CLEAR: begin
			queued = 0;
			w.status = ST_CLEARED;
			awaited_results.push_back(w);
		end
		default: ;
		endcase
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		checked++;
		if (awaited_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result st=%0d time=%h now=%h kind=%0d hnd=%h pay=%h last=%b",
					$time, got.status, got.ftime, got.now, got.kind, got.handler,
					got.payload, got.last);
		end else begin
			want = awaited_results.pop_front();
			if (want.status == ST_DUE)
				fired++;
			if (want.status == ST_FULL)
				dropped++;
			if (got.status !== want.status || got.ftime !== want.ftime
					|| got.now !== want.now || got.kind !== want.kind
					|| got.handler !== want.handler || got.payload !== want.payload
					|| got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected st=%0d time=%h now=%h kind=%0d hnd=%h pay=%h last=%b",
						want.status, want.ftime, want.now, want.kind, want.handler,
						want.payload, want.last);
					$display("  actual   st=%0d time=%h now=%h kind=%0d hnd=%h pay=%h last=%b",
						got.status, got.ftime, got.now, got.kind, got.handler,
						got.payload, got.last);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued = 0;
			awaited_results.delete();
			pending_words <= 0;
		end else begin
			// request first: its results cannot show up in the same cycle
			if (in_valid && in_ready)
				predict_request(req_type, req_time, payload_kind, handler_id, payload_value);
			if (out_valid && out_ready)
				check_result({status, fired_time, current_time, fired_kind, fired_handler,
					fired_payload, last_result});
			pending_words   <= awaited_results.size();
			mismatch_count  <= mismatches;
			results_checked <= checked;
			events_fired    <= fired;
			events_dropped  <= dropped;
		end
	end

endmodule

// ===== sim/tb_timed_event_queue_top.sv =====
module tb_timed_event_queue_top;
	import teq_pkg::*;

	localparam int RANDOM_WORDS = 100;
	localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES = 64;    // > one full pop burst plus margin

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = REQ_SCHEDULE;
	logic [31:0] req_time = '0;
	logic [1:0]  payload_kind = '0;
	logic [7:0]  handler_id = '0;
	logic [63:0] payload_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] fired_time;
	logic [31:0] current_time;
	logic [1:0]  fired_kind;
	logic [7:0]  fired_handler;
	logic [63:0] fired_payload;
	logic        last_result;

	int mismatch_count;
	int pending_words;
	int results_checked;
	int events_fired;
	int events_dropped;

	// idle rates in percent; the stimulus moves them between phases
	int   send_idle_pct = 37;
	int   recv_idle_pct = 51;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;
	int   words_sent = 0;   // request words the block acts on (type 3 excluded)

	always #4 clk = ~clk;

	timed_event_queue_top #(
		.QUEUE_DEPTH(32)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.req_time      (req_time),
		.payload_kind  (payload_kind),
		.handler_id    (handler_id),
		.payload_value (payload_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.fired_time    (fired_time),
		.current_time  (current_time),
		.fired_kind    (fired_kind),
		.fired_handler (fired_handler),
		.fired_payload (fired_payload),
		.last_result   (last_result)
	);

	timed_event_queue_checker #(
		.QUEUE_DEPTH(32)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.req_time        (req_time),
		.payload_kind    (payload_kind),
		.handler_id      (handler_id),
		.payload_value   (payload_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.fired_time      (fired_time),
		.current_time    (current_time),
		.fired_kind      (fired_kind),
		.fired_handler   (fired_handler),
		.fired_payload   (fired_payload),
		.last_result     (last_result),
		.mismatch_count  (mismatch_count),
		.pending_words   (pending_words),
		.results_checked (results_checked),
		.events_fired    (events_fired),
		.events_dropped  (events_dropped)
	);

	// Result side. One long hold-off on request, random stalls otherwise.
	// The hold is counted here so the sender keeps offering words and the
	// block has to back up into in_ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= LONG_HOLD;
			out_ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one request word and wait for it to be taken. Gaps go in front,
	// so valid is only dropped in a step where it is not raised again.
	task automatic send_word(input logic [1:0] rtype, input logic [31:0] t,
			input logic [1:0] kind, input logic [7:0] hnd, input logic [63:0] pay);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= rtype;
		req_time      <= t;
		payload_kind  <= kind;
		handler_id    <= hnd;
		payload_value <= pay;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (rtype != REQ_UNUSED)
			words_sent++;
	endtask

	// schedule with random kind, handler and payload
	task automatic post_event(input logic [31:0] t);
		send_word(REQ_SCHEDULE, t, 2'($urandom_range(3)), 8'($urandom_range(255)),
			{$urandom, $urandom});
	endtask

	// process: the unused fields still carry random bits
	task automatic process_due(input logic [31:0] now);
		send_word(REQ_PROCESS, now, 2'($urandom_range(3)), 8'($urandom_range(255)),
			{$urandom, $urandom});
	endtask

	task automatic clear_queue();
		send_word(REQ_CLEAR, $urandom, 2'($urandom_range(3)), 8'($urandom_range(255)),
			{$urandom, $urandom});
	endtask

	// From empty: 32 events over a narrow window (lots of equal times),
	// two more that must be dropped, then one process that drains everything
	// in one go (max result count) and a second that finds nothing.
	task automatic fill_queue();
		int k;
		clear_queue();
		for (k = 0; k < 34; k++)
			post_event($urandom_range(20));
		process_due(32'hFFFF_FFFF);
		process_due(32'hFFFF_FFFF);
	endtask

	initial begin
		int          directed_words;
		int          phase;
		int          pick;
		int          len;
		int          k;
		logic [31:0] base;
		logic [31:0] now;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		process_due(32'd0);                                   // empty queue: none due
		send_word(REQ_SCHEDULE, 32'hFFFF_FFFF, 2'd3, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(REQ_SCHEDULE, 32'd0, 2'd0, 8'h00, 64'h0);
		send_word(REQ_SCHEDULE, 32'd100, 2'd1, 8'h01, 64'h5555_5555_5555_5555);
		send_word(REQ_SCHEDULE, 32'd100, 2'd2, 8'h02, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(REQ_SCHEDULE, 32'd50, 2'd1, 8'h03, 64'h0123_4567_89AB_CDEF);
		send_word(REQ_UNUSED, 32'd100, 2'd3, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF); // ignored
		process_due(32'd99);                                  // pops time 0 and 50
		process_due(32'd99);                                  // nothing due now
		process_due(32'd100);                                 // equal times, arrival order
		process_due(32'hFFFF_FFFF);                           // top time
		post_event(32'd7);
		clear_queue();
		process_due(32'hFFFF_FFFF);                           // cleared: none due
		clear_queue();                                        // clear when already empty
		directed_words = words_sent;

		// ---- random part ----
		// first sequence fills the queue to the brim and beyond
		fill_queue();
		phase = 1;
		// keep going until the last phase (with its long hold-off) has run
		while (words_sent < directed_words + RANDOM_WORDS || phase < 3) begin
			if (phase == 1 && words_sent >= directed_words + RANDOM_WORDS / 3) begin
				phase = 2;
				send_idle_pct = 51;
				recv_idle_pct <= 37;
			end else if (phase == 2
					&& words_sent >= directed_words + 2 * RANDOM_WORDS / 3) begin
				phase = 3;
				send_idle_pct = 0;
				recv_idle_pct <= 0;
				// receiver goes quiet while schedules keep coming
				hold_req <= 1'b1;
				for (k = 0; k < 10; k++)
					post_event($urandom);
				process_due(32'hFFFF_FFFF);
			end
			pick = $urandom_range(99);
			if (pick < 45) begin
				// burst around a base time, then a process somewhere near it
				case ($urandom_range(3))
				0: base = $urandom_range(15);
				1: base = 32'hFFFF_FFF0 + $urandom_range(8);
				default: base = $urandom;
				endcase
				len = $urandom_range(1, 10);
				for (k = 0; k < len; k++)
					post_event(base + $urandom_range(7));
				case ($urandom_range(3))
				0: now = base - 1;
				1: now = base + $urandom_range(7);
				2: now = 32'hFFFF_FFFF;
				default: now = $urandom;
				endcase
				process_due(now);
			end else if (pick < 55) begin
				process_due($urandom_range(1) ? $urandom : 32'hFFFF_FFFF);
			end else if (pick < 65) begin
				clear_queue();
			end else if (pick < 72) begin
				send_word(REQ_UNUSED, $urandom, 2'($urandom_range(3)), 8'($urandom_range(255)),
					{$urandom, $urandom});
			end else if (pick < 76) begin
				fill_queue();
			end else if (pick < 88) begin
				case ($urandom_range(2))
				0: post_event(32'd0);
				1: post_event(32'hFFFF_FFFF);
				default: post_event($urandom);
				endcase
			end else begin
				// same now twice: the second finds only what the first left by its pop budget
				now = $urandom;
				process_due(now);
				process_due(now);
			end
		end
		in_valid <= 1'b0;

		// wait for every expected result, then watch a while for strays
		do
			@(posedge clk);
		while (pending_words != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d request words, %0d result words checked, %0d events fired,",
			words_sent, results_checked, events_fired);
		$display("  %0d schedules dropped on a full queue, one %0d-cycle receiver hold-off.",
			events_dropped, LONG_HOLD);
		if (mismatch_count == 0 && pending_words == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
